@@ hw/rtl/sha_pkg.sv @@
// SHA-256 shared package: round constants, initial hash values, helper functions.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [31:0] word_t;

  // Round control from sequencer to the round core
  typedef struct packed {
    logic       load;    // load working vars from chain state
    logic       step;    // run one round
    logic       fold;    // add working vars into chain state
    logic       init;    // reset chain state to initial values
    logic [5:0] rnd;     // round index
  } core_ctl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    unique case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[i];
  endfunction

  function automatic word_t swap32(input word_t x);
    swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

@@ hw/rtl/sha_core.sv @@
// SHA-256 round core: message schedule window, one round per cycle, chain state.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_core import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  core_ctl_t ctl,
  input  logic      wr_en,      // shift a block word into the schedule window
  input  word_t     wr_word,
  input  logic [2:0] rd_idx,
  output word_t     rd_word
);

  word_t w [16];
  word_t v [8];
  word_t h [8];
  word_t w_new, t1, t2, s0, s1, e, a;

  // Schedule word for the next window slot and the round sums
  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    e = v[4];
    a = v[0];
    t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
       + round_k(ctl.rnd) + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  assign rd_word = h[rd_idx];

  // Advance the window, the working variables and the chain state
  always_ff @(posedge clk) begin
    if (wr_en || ctl.step) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wr_en ? wr_word : w_new;
    end
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (ctl.step) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
    if (rst || ctl.init) begin
      for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
    end
  end

endmodule

@@ hw/rtl/sha256_stream_hasher.sv @@
// SHA-256 stream hasher top level: input sequencer, padding, output of the digest.
// Depends on sha_pkg and sha_core.
//
//  channel | signals                                               | direction
//  in      | in_valid, in_stall, data_word, valid_bytes, last_word | into block
//  out     | out_valid, out_stall, digest_word, digest_last        | out of block
//  cfg     | cfg_valid, cfg_ready, cfg_data                        | into block
//
// Each word is shifted into the schedule window as it is taken; the 16th word of a
// block starts a load step, 64 rounds and a fold step on the shared round core, and
// in_stall is high while the block is busy. The last item adds padding words one a
// cycle up to one or two full blocks, plus one more block for the double hash when
// dbl_mode is set, then eight digest words one a cycle. Reset is synchronous and
// restores the initial hash; digest words wait in place while out_stall is high.
`timescale 1ns / 1ps
module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic        digest_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  typedef enum logic [2:0] {
    S_IN, S_PAD, S_LOAD, S_RUN, S_FOLD, S_OUT
  } state_t;

  localparam word_t PadMarker = 32'h8000_0000;
  localparam word_t DblLength = 32'd256;

  state_t      state;
  logic        dbl_mode;
  logic [3:0]  fill;
  logic [63:0] msg_bits;
  logic [5:0]  rnd;
  logic        pad_final;     // padding of the message in progress
  logic        second;        // running the double-hash block
  logic        mark_pending;  // the 0x80 marker word is still to be written
  logic        len_ok;        // length words fit in the current block
  logic        fin;           // the final block of the message is running
  logic [3:0]  pad_cnt;
  logic [2:0]  out_idx;
  core_ctl_t   ctl;
  logic        wr_en;
  word_t       wr_word;
  word_t       rd_word;
  logic [2:0]  rd_idx;
  logic [2:0]  nv;
  word_t       keep, last_w;
  logic        accept;

  assign in_stall  = (state != S_IN);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // Masked last word with its 0x80 marker
  always_comb begin
    nv = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    keep = (nv == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {nv, 3'b000}));
    last_w = (data_word & keep) | (32'h80 << (5'd24 - {nv[1:0], 3'b000}));
  end

  // Chain word read back: digest output, or the first digest for the double block
  always_comb begin
    if (state == S_OUT) rd_idx = dbl_mode ? 3'd7 - out_idx : out_idx;
    else rd_idx = pad_cnt[2:0];
  end

  sha_core u_core (
    .clk(clk), .rst(rst), .ctl(ctl), .wr_en(wr_en), .wr_word(wr_word),
    .rd_idx(rd_idx), .rd_word(rd_word)
  );

  // Word fed to the window and round control
  always_comb begin
    wr_en = 1'b0;
    wr_word = '0;
    if (accept) begin
      wr_en = 1'b1;
      wr_word = (last_word && nv != 3'd4) ? last_w : data_word;
    end else if (state == S_PAD) begin
      wr_en = 1'b1;
      if (second) begin
        if (pad_cnt < 4'd8) wr_word = rd_word;
        else if (pad_cnt == 4'd8) wr_word = PadMarker;
        else if (pad_cnt == 4'd15) wr_word = DblLength;
      end else if (mark_pending) begin
        wr_word = PadMarker;
      end else if (len_ok && fill == 4'd14) begin
        wr_word = msg_bits[63:32];
      end else if (len_ok && fill == 4'd15) begin
        wr_word = msg_bits[31:0];
      end
    end
    ctl.load = (state == S_LOAD);
    ctl.step = (state == S_RUN);
    ctl.fold = (state == S_FOLD);
    ctl.init = (state == S_PAD && second && pad_cnt == 4'd15) ||
               (state == S_OUT && !out_stall && out_idx == 3'd7);
    ctl.rnd  = rnd;
  end

  assign digest_word = dbl_mode ? swap32(rd_word) : rd_word;
  assign digest_last = (out_idx == 3'd7);
  assign out_valid   = (state == S_OUT);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN; dbl_mode <= 1'b0; fill <= '0; msg_bits <= '0; rnd <= '0;
      pad_final <= 1'b0; second <= 1'b0; mark_pending <= 1'b0; len_ok <= 1'b0;
      fin <= 1'b0; pad_cnt <= '0; out_idx <= '0;
    end else begin
      if (cfg_valid && cfg_ready) dbl_mode <= cfg_data;
      unique case (state)
        S_IN: if (accept) begin
          fill <= fill + 4'd1;
          if (!last_word) begin
            msg_bits <= msg_bits + 64'd32;
          end else begin
            msg_bits <= msg_bits + {58'd0, nv, 3'b000};
            pad_final <= 1'b1;
            fin <= 1'b0;
            // full last word still needs the 0x80 marker word
            mark_pending <= (nv == 3'd4);
            len_ok <= (fill <= 4'd13);
          end
          if (fill == 4'd15) state <= S_LOAD;
          else if (last_word) state <= S_PAD;
        end
        S_PAD: begin
          if (second) begin
            pad_cnt <= pad_cnt + 4'd1;
            if (pad_cnt == 4'd15) state <= S_LOAD;
          end else begin
            fill <= fill + 4'd1;
            if (mark_pending) begin
              mark_pending <= 1'b0;
              len_ok <= (fill <= 4'd13);
            end else if (len_ok && fill == 4'd15) begin
              fin <= 1'b1;
            end
            if (fill == 4'd15) state <= S_LOAD;
          end
        end
        S_LOAD: begin
          rnd <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          if (!pad_final) begin
            state <= S_IN;
          end else if (!fin) begin
            len_ok <= 1'b1;
            state <= S_PAD;
          end else if (dbl_mode && !second) begin
            second <= 1'b1;
            pad_cnt <= '0;
            state <= S_PAD;
          end else begin
            out_idx <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) begin
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'd7) begin
            state <= S_IN; msg_bits <= '0; pad_final <= 1'b0;
            second <= 1'b0; fin <= 1'b0;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IN) |-> in_stall) else $error("input taken while busy");
  a_last_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && digest_last) |=> !out_valid) else $error("extra digest word");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD) |-> $past(rnd) == 6'd63) else $error("round count slip");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(digest_word))
    else $error("digest word changed while stalled");
`endif

endmodule
